// File: rtl/core/idct_8x8_block_top_assert.svh
// Assertion macros used by the IDCT block top level.
`ifndef IDCT_8X8_BLOCK_TOP_ASSERT_SVH
`define IDCT_8X8_BLOCK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IDCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idct assertion failed");
`define IDCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("idct assertion failed");
`else
`define IDCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IDCT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/idct_pkg.sv
// Package: shared types, constants and the basis table of the IDCT block.
`timescale 1ns / 1ps
package idct_pkg;
    localparam int BLOCK_CELLS = 64;
    localparam int COEF_W      = 12;
    localparam int ROW_W       = 20;
    localparam int BASIS_W     = 14;
    localparam int PROD_W      = ROW_W + BASIS_W;
    localparam int ACC_W       = 37;
    localparam int SAMPLE_W    = 11;

    localparam logic signed [BASIS_W-1:0] COS_Q12 [0:8] = '{
        14'sd4096, 14'sd4017, 14'sd3784, 14'sd3406, 14'sd2896,
        14'sd2276, 14'sd1567, 14'sd799, 14'sd0
    };
    localparam logic signed [BASIS_W-1:0] DC_BASIS = 14'sd2896;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAC,
        B_DRAIN,
        B_DONE
    } back_state_t;

    // bank handover between front and back
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_msg_t;

    // B(k,n): C(k)/2 * cos((2n+1)k pi/16), 13 fractional bits
    function automatic logic signed [BASIS_W-1:0] basis(input logic [2:0] k,
                                                      input logic [2:0] n);
        logic [6:0] prod;
        logic [4:0] a;
        logic signed [BASIS_W-1:0] r;
        prod = {3'b000, n, 1'b1} * {4'b0000, k};
        a = prod[4:0];
        if (a > 5'd16)
            a = 5'(6'd32 - {1'b0, a});
        if (k == 3'd0)
            r = DC_BASIS;
        else if (a > 5'd8)
            r = -COS_Q12[4'(5'd16 - a)];
        else
            r = COS_Q12[a[3:0]];
        return r;
    endfunction
endpackage

// File: rtl/core/idct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module idct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/idct_front.sv
// Front end: takes coefficients, fills one of two banks, hands full banks on.
`timescale 1ns / 1ps
module idct_front
    import idct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coefficient_valid,
    output logic              coefficient_stall,
    input  logic [COEF_W-1:0] coefficient,
    input  bank_msg_t         release_msg,
    output logic              coef_we,
    output logic [6:0]        coef_waddr,
    output logic [COEF_W-1:0] coef_wdata,
    output bank_msg_t         push_msg
);
    logic [5:0] cnt_reg, cnt_next;
    logic       bank_reg, bank_next;
    logic [1:0] busy_reg, busy_next;
    logic       accept;

    assign coefficient_stall = busy_reg[bank_reg];
    assign accept     = coefficient_valid && !busy_reg[bank_reg];
    assign coef_we    = accept;
    assign coef_waddr = {bank_reg, cnt_reg};
    assign coef_wdata = coefficient;

    always_comb
    begin
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        busy_next      = busy_reg;
        push_msg.valid = 1'b0;
        push_msg.bank  = bank_reg;
        if (release_msg.valid)
            busy_next[release_msg.bank] = 1'b0;
        if (accept)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(BLOCK_CELLS - 1))
            begin
                busy_next[bank_reg] = 1'b1;
                push_msg.valid      = 1'b1;
                bank_next           = !bank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end
endmodule

// File: rtl/core/idct_queue.sv
// Two-entry queue of full bank numbers between front and back.
`timescale 1ns / 1ps
module idct_queue
    import idct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bank_msg_t push_msg,
    input  logic      pop,
    output logic      empty,
    output logic      full,
    output logic      head_bank
);
    logic [1:0] data_reg, data_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign empty     = (cnt_reg == 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head_bank = data_reg[rd_ptr_reg];
    assign do_pop    = pop && !empty;

    always_comb
    begin
        data_next   = data_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_msg.valid)
        begin
            data_next[wr_ptr_reg] = push_msg.bank;
            wr_ptr_next           = !wr_ptr_reg;
        end
        if (do_pop)
            rd_ptr_next = !rd_ptr_reg;
        if (push_msg.valid && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push_msg.valid && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end
endmodule

// File: rtl/core/idct_back.sv
// Back end: row pass then column pass on one shared multiply-accumulate unit.
`timescale 1ns / 1ps
module idct_back
    import idct_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  logic                       q_bank,
    output logic                       q_pop,
    output bank_msg_t                  release_msg,
    output logic [6:0]                 coef_raddr,
    input  logic [COEF_W-1:0]          coef_rdata,
    output logic                       row_we,
    output logic [5:0]                 row_waddr,
    output logic [ROW_W-1:0]           row_wdata,
    output logic [5:0]                 row_raddr,
    input  logic [ROW_W-1:0]           row_rdata,
    output logic                       sample_valid,
    input  logic                       sample_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_of_block
);
    back_state_t state_reg, state_next;
    logic        pass_reg, pass_next;       // 0 row pass, 1 column pass
    logic        bank_reg, bank_next;
    logic [5:0]  elem_reg, elem_next;
    logic [2:0]  tap_reg, tap_next;
    logic        s1_v_reg;
    logic [2:0]  s1_tap_reg;
    logic        s2_v_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic        out_v_reg, out_v_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic        last_reg, last_next;
    logic        issue, acc_clear, can_load;
    logic signed [ROW_W-1:0]  operand;
    logic signed [ACC_W-1:0]  row_rnd, col_rnd;
    logic signed [17:0]       col_val;

    assign can_load = !out_v_reg || !sample_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = B_MAC;
            B_MAC:
                if (tap_reg == 3'd7)
                    state_next = B_DRAIN;
            B_DRAIN:
                if (!s1_v_reg && !s2_v_reg)
                    state_next = B_DONE;
            B_DONE:
                if (!pass_reg)
                    state_next = B_MAC;
                else if (can_load)
                    state_next = (elem_reg == 6'(BLOCK_CELLS - 1)) ? B_IDLE : B_MAC;
            default:
                state_next = B_IDLE;
        endcase
    end

    assign row_rnd = acc_reg + ACC_W'(64);
    assign col_rnd = acc_reg + ACC_W'(262144);
    assign col_val = col_rnd[36:19];
    assign operand = pass_reg ? $signed(row_rdata)
                              : ROW_W'($signed(coef_rdata));
    assign prod_next = operand * basis(s1_tap_reg,
                                       pass_reg ? elem_reg[5:3] : elem_reg[2:0]);
    assign coef_raddr = {bank_reg, elem_reg[5:3], tap_reg};
    assign row_raddr  = {tap_reg, elem_reg[2:0]};
    assign row_waddr  = elem_reg;
    assign row_wdata  = row_rnd[26:7];

    // outputs and datapath control
    always_comb
    begin
        pass_next         = pass_reg;
        bank_next         = bank_reg;
        elem_next         = elem_reg;
        tap_next          = tap_reg;
        issue             = 1'b0;
        acc_clear         = 1'b0;
        q_pop             = 1'b0;
        row_we            = 1'b0;
        release_msg.valid = 1'b0;
        release_msg.bank  = bank_reg;
        out_v_next        = out_v_reg && sample_stall;
        sample_next       = sample_reg;
        last_next         = last_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    bank_next = q_bank;
                    pass_next = 1'b0;
                    elem_next = '0;
                    tap_next  = '0;
                    acc_clear = 1'b1;
                end
            B_MAC:
            begin
                issue    = 1'b1;
                tap_next = tap_reg + 3'd1;
            end
            B_DRAIN:
                ;
            B_DONE:
                if (!pass_reg)
                begin
                    row_we    = 1'b1;
                    acc_clear = 1'b1;
                    tap_next  = '0;
                    elem_next = elem_reg + 6'd1;
                    if (elem_reg == 6'(BLOCK_CELLS - 1))
                    begin
                        pass_next         = 1'b1;
                        release_msg.valid = 1'b1;
                    end
                end
                else if (can_load)
                begin
                    out_v_next = 1'b1;
                    if (col_val < -18'sd1024)
                        sample_next = -11'sd1024;
                    else if (col_val > 18'sd1023)
                        sample_next = 11'sd1023;
                    else
                        sample_next = col_val[10:0];
                    last_next = (elem_reg == 6'(BLOCK_CELLS - 1));
                    acc_clear = 1'b1;
                    tap_next  = '0;
                    elem_next = elem_reg + 6'd1;
                    if (elem_reg == 6'(BLOCK_CELLS - 1))
                        pass_next = 1'b0;
                end
            default:
                ;
        endcase
        if (acc_clear)
            acc_next = '0;
        else if (s2_v_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pass_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        elem_reg   <= elem_next;
        tap_reg    <= tap_next;
        s1_tap_reg <= tap_reg;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    assign sample_valid  = out_v_reg;
    assign sample        = sample_reg;
    assign last_of_block = last_reg;
endmodule

// File: rtl/core/idct_8x8_block_top.sv
// Top level of the 8x8 inverse cosine transform block.
//
//  channel      dir  handshake                      payload
//  coefficient  in   coefficient_valid / _stall     coefficient[11:0] signed
//  sample       out  sample_valid / sample_stall    sample[10:0], last_of_block
//
// One coefficient is taken per cycle while a bank is free; two banks of
// coefficient RAM let one block load while the previous one is transformed.
// The back end runs one multiply-accumulate unit: 64 row outputs and then
// 64 column outputs, each 8 taps, then a drain of the multiply pipeline and
// a write to the row RAM or a sample load; one block is transformed at a time.
// Reset clears control only; RAM contents are undefined until written.
// A stalled sample holds in the output register and the back end waits.
`timescale 1ns / 1ps
`include "idct_8x8_block_top_assert.svh"
module idct_8x8_block_top
    import idct_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       coefficient_valid,
    output logic                       coefficient_stall,
    input  logic signed [COEF_W-1:0]   coefficient,
    output logic                       sample_valid,
    input  logic                       sample_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_of_block
);
    bank_msg_t           push_msg, release_msg;
    logic                coef_we;
    logic [6:0]          coef_waddr, coef_raddr;
    logic [COEF_W-1:0]   coef_wdata, coef_rdata;
    logic                row_we;
    logic [5:0]          row_waddr, row_raddr;
    logic [ROW_W-1:0]    row_wdata, row_rdata;
    logic                q_pop, q_empty, q_full, q_bank;

    idct_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .coefficient_valid (coefficient_valid),
        .coefficient_stall (coefficient_stall),
        .coefficient       (coefficient),
        .release_msg       (release_msg),
        .coef_we           (coef_we),
        .coef_waddr        (coef_waddr),
        .coef_wdata        (coef_wdata),
        .push_msg          (push_msg)
    );

    // two banks of 64 coefficients
    idct_ram #(.WIDTH(COEF_W), .DEPTH(2 * BLOCK_CELLS)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    idct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_msg  (push_msg),
        .pop       (q_pop),
        .empty     (q_empty),
        .full      (q_full),
        .head_bank (q_bank)
    );

    // row pass results, 6 fractional bits
    idct_ram #(.WIDTH(ROW_W), .DEPTH(BLOCK_CELLS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    idct_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_bank        (q_bank),
        .q_pop         (q_pop),
        .release_msg   (release_msg),
        .coef_raddr    (coef_raddr),
        .coef_rdata    (coef_rdata),
        .row_we        (row_we),
        .row_waddr     (row_waddr),
        .row_wdata     (row_wdata),
        .row_raddr     (row_raddr),
        .row_rdata     (row_rdata),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .last_of_block (last_of_block)
    );

    // bank hand-offs never overrun or underrun the queue
    `IDCT_ASSERT_IMP(a_no_push_full, clk, rst_n, push_msg.valid, !q_full || q_pop)
    `IDCT_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
    // a bank being released is never the one just completed
    `IDCT_ASSERT_NEVER(a_release_push, clk, rst_n,
        push_msg.valid && release_msg.valid && (push_msg.bank == release_msg.bank))
endmodule

// File: tb/idct_8x8_block_top_test.sv
// Self-checking testbench for the 8x8 inverse cosine transform block.
`timescale 1ns / 1ps
module idct_8x8_block_top_test;
    import idct_pkg::*;

    // Expected sample and block-end flag for one output transaction
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } pixel_t;

    // Holds the coefficients of the block being loaded and the pixels still owed
    class idct_scoreboard;
        int             coef_block [0:63];
        int             coef_fill;
        pixel_t         pixel_queue [$];
        int             error_count;

        function new();
            coef_fill   = 0;
            error_count = 0;
        endfunction

        // round(4096*cos((2n+1)*k*pi/16)), with the DC term scaled by 1/sqrt2
        function int cos_factor(int k, int n);
            int angle;
            int cos_q12 [0:8];
            cos_q12 = '{4096, 4017, 3784, 3406, 2896, 2276, 1567, 799, 0};
            if (k == 0)
                return 2896;
            angle = ((2 * n + 1) * k) % 32;
            if (angle > 16)
                angle = 32 - angle;
            if (angle > 8)
                return -cos_q12[16 - angle];
            return cos_q12[angle];
        endfunction

        // Separable row then column pass; >>> on longint gives floor division
        function void transform_block();
            longint row_pass [0:63];
            longint acc;
            pixel_t pix;
            for (int v = 0; v < 8; v++)
                for (int x = 0; x < 8; x++)
                begin
                    acc = 0;
                    for (int u = 0; u < 8; u++)
                        acc += longint'(cos_factor(u, x)) * coef_block[v * 8 + u];
                    row_pass[v * 8 + x] = (acc + 64) >>> 7;
                end
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++)
                begin
                    acc = 0;
                    for (int v = 0; v < 8; v++)
                        acc += longint'(cos_factor(v, y)) * row_pass[v * 8 + x];
                    acc = (acc + (longint'(1) << 18)) >>> 19;
                    if (acc < -1024)
                        acc = -1024;
                    if (acc > 1023)
                        acc = 1023;
                    pix.sample = SAMPLE_W'(acc);
                    pix.last   = (y == 7 && x == 7);
                    pixel_queue.push_back(pix);
                end
        endfunction

        function void note_coefficient(logic signed [COEF_W-1:0] c);
            coef_block[coef_fill] = c;
            coef_fill++;
            if (coef_fill == 64)
            begin
                coef_fill = 0;
                transform_block();
            end
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] s, logic l);
            pixel_t exp_pix;
            if (pixel_queue.size() == 0)
            begin
                $error("unexpected sample transaction: sample %0d", s);
                error_count++;
                return;
            end
            exp_pix = pixel_queue.pop_front();
            if (s !== exp_pix.sample)
            begin
                $error("sample: expected %0d, got %0d", exp_pix.sample, s);
                error_count++;
            end
            if (l !== exp_pix.last)
            begin
                $error("last_of_block: expected %0b, got %0b", exp_pix.last, l);
                error_count++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       coefficient_valid;
    logic                       coefficient_stall;
    logic signed [COEF_W-1:0]   coefficient;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_block;

    idct_scoreboard board;

    idct_8x8_block_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .coefficient_valid (coefficient_valid),
        .coefficient_stall (coefficient_stall),
        .coefficient       (coefficient),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample            (sample),
        .last_of_block     (last_of_block)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, the odd long one, and runs with none at all
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive one coefficient and hold it until the block takes the transaction
    task automatic send_coefficient(logic signed [COEF_W-1:0] value);
        int gap;
        gap = gap_length();
        repeat (gap)
        begin
            coefficient_valid <= 1'b0;
            @(posedge clk);
        end
        coefficient_valid <= 1'b1;
        coefficient       <= value;
        @(posedge clk);
        while (coefficient_stall)
            @(posedge clk);
        board.note_coefficient(value);
    endtask

    // Random coefficient: mostly small AC-like values, some full-scale
    function automatic logic signed [COEF_W-1:0] random_coefficient();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return COEF_W'($signed($urandom_range(0, 64)) - 32);
        if (pick < 8)
            return COEF_W'($urandom);
        return pick == 8 ? 12'sh7FF : 12'sh800;
    endfunction

    // Receiver: stalls at random, checks every accepted sample transaction
    initial
    begin
        sample_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sample_valid && !sample_stall)
                board.check_sample(sample, last_of_block);
            sample_stall <= (gap_length() != 0) && ($urandom_range(0, 1) == 1);
        end
    end

    initial
    begin
        int idle_wait;
        board             = new();
        rst_n             = 1'b0;
        coefficient_valid = 1'b0;
        coefficient       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale positive block saturates high, zero block, then
        // full-scale negative DC with alternating AC to reach both rails
        for (int i = 0; i < 64; i++)
            send_coefficient(12'sh7FF);
        for (int i = 0; i < 64; i++)
            send_coefficient(12'sh000);
        for (int i = 0; i < 64; i++)
            send_coefficient(i == 0 ? 12'sh800 : ((i % 2) ? 12'sh7FF : 12'sh800));

        // Random tail: one full block plus a partial one, about 280 in all
        for (int i = 0; i < 88; i++)
            send_coefficient(random_coefficient());
        coefficient_valid <= 1'b0;

        // Drain: wait for every owed pixel, then a further quiet wait
        idle_wait = 0;
        while (board.pixel_queue.size() != 0 && idle_wait < 200000)
        begin
            @(posedge clk);
            idle_wait++;
        end
        repeat (2000) @(posedge clk);

        if (board.error_count == 0 && board.pixel_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: 4 blocks plus worst-case stalls, with a wide margin
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
